[src/ptb_pkg.sv]
// ptb_pkg: shared types and constants for the polled timer bank
// no dependencies; used by ptb_upd and polled_timer_bank
`timescale 1ns / 1ps

package ptb_pkg;

    localparam int IDX_W          = 4;    // width of the timer index field
    localparam int CNT_W          = 16;   // width of count and period fields
    localparam int IDX_EXT_W      = 9;    // holds any bank size up to 256
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TICK_BITS_DEF  = 8;

    typedef logic [1:0] t_action;

    localparam t_action ACT_SET   = 2'd0;
    localparam t_action ACT_POLL  = 2'd1;
    localparam t_action ACT_RESET = 2'd2;
    localparam t_action ACT_TICK  = 2'd3;

    // status handed from the update logic back to the control
    typedef struct packed {
        logic we;        // entry must be written back
        logic active;    // new active flag of the addressed timer
        logic fired;
        logic running;
    } t_upd_res;

endpackage

[src/ptb_mem.sv]
// ptb_mem: one-port-write, one-port-read timer entry memory, registered read
// no dependencies
`timescale 1ns / 1ps

module ptb_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ptb_upd.sv]
// ptb_upd: modify step of the read-modify-write on one timer entry
// depends on ptb_pkg
`timescale 1ns / 1ps

module ptb_upd #(
    parameter int TICK_BITS = 8
) (
    input  ptb_pkg::t_action                     i_action,
    input  logic                                 i_idx_ok,
    input  logic                                 i_active,
    input  logic [TICK_BITS+2*ptb_pkg::CNT_W-1:0] i_entry,
    input  logic [TICK_BITS-1:0]                 i_tick,
    input  logic [ptb_pkg::CNT_W-1:0]            i_start_count,
    input  logic [ptb_pkg::CNT_W-1:0]            i_reload_period,
    output logic [TICK_BITS+2*ptb_pkg::CNT_W-1:0] o_entry,
    output ptb_pkg::t_upd_res                    o_res
);
    import ptb_pkg::*;

    logic [TICK_BITS-1:0] last_seen;
    logic [CNT_W-1:0]     remaining;
    logic [CNT_W-1:0]     reload;
    logic [CNT_W-1:0]     rem_dec;
    logic [TICK_BITS-1:0] n_last;
    logic [CNT_W-1:0]     n_rem;
    logic [CNT_W-1:0]     n_reload;
    logic                 n_active;
    logic                 fired;
    logic                 we;

    assign {last_seen, remaining, reload} = i_entry;
    assign rem_dec = remaining - CNT_W'(1);

    always_comb begin
        n_last   = last_seen;
        n_rem    = remaining;
        n_reload = reload;
        n_active = i_active;
        fired    = 1'b0;
        we       = 1'b0;
        if (i_idx_ok) begin
            case (i_action)
                ACT_SET: begin
                    we       = 1'b1;
                    n_active = 1'b1;
                    // zero count: make the next poll see a new tick
                    n_last   = (i_start_count == '0) ? ~i_tick : i_tick;
                    n_rem    = i_start_count;
                    n_reload = i_reload_period;
                end
                ACT_POLL: begin
                    if (i_active && last_seen != i_tick) begin
                        we     = 1'b1;
                        n_last = i_tick;
                        if (remaining == '0) begin
                            fired = 1'b1;
                            if (reload != '0) begin
                                n_rem = reload;
                            end
                        end else if (rem_dec == '0) begin
                            fired = 1'b1;
                            if (reload == '0) begin
                                n_active = 1'b0;
                                n_rem    = '0;
                            end else begin
                                n_rem = reload;
                            end
                        end else begin
                            n_rem = rem_dec;
                        end
                    end
                end
                ACT_RESET: begin
                    we       = 1'b1;
                    n_active = 1'b0;
                    n_last   = '0;
                    n_rem    = '0;
                    n_reload = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_entry       = {n_last, n_rem, n_reload};
    assign o_res.we      = we;
    assign o_res.active  = n_active;
    assign o_res.fired   = fired;
    assign o_res.running = i_idx_ok && n_active;

endmodule

[src/polled_timer_bank.sv]
// polled_timer_bank: top level, request control, active flags, tick counter
// depends on ptb_pkg, ptb_mem, ptb_upd
`timescale 1ns / 1ps
//
// Usage
//   A request is taken at a rising edge with i_start high and o_busy low.
//   Fields: i_action (set, poll, reset timer, system tick), i_timer_index,
//   i_start_count and i_reload_period (used by set only).
//   Every request yields one result: o_strobe is high for exactly one cycle
//   with o_fired and o_still_running valid in that cycle; the receiver
//   cannot hold it off.
//   The accepting edge raises o_busy for the modify cycle, and o_strobe is
//   o_busy registered, so the result cycle directly follows the modify cycle.
//   No new request is taken while o_busy is high. The accepting edge reads
//   the addressed timer entry from the synchronous entry memory; the modify
//   cycle then updates the entry and writes it back.
//   Reset (i_rst_n low, synchronous) clears the tick counter, all active
//   flags and the request control; entry memory contents are not cleared
//   since an entry is only used while its timer is active.
//   Set, poll or reset at an index beyond the bank is ignored, reports zeros.
//
module polled_timer_bank #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
    parameter int TICK_BITS  = ptb_pkg::TICK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  ptb_pkg::t_action             i_action,
    input  logic [ptb_pkg::IDX_W-1:0]    i_timer_index,
    input  logic [ptb_pkg::CNT_W-1:0]    i_start_count,
    input  logic [ptb_pkg::CNT_W-1:0]    i_reload_period,
    output logic                         o_strobe,
    output logic                         o_fired,
    output logic                         o_still_running
);
    import ptb_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int EW = TICK_BITS + 2 * CNT_W;

    logic                  r_busy;
    t_action               r_action;
    logic                  r_idx_ok;
    logic [AW-1:0]         r_addr;
    logic [CNT_W-1:0]      r_start;
    logic [CNT_W-1:0]      r_period;
    logic [TICK_BITS-1:0]  r_tick;
    logic [NUM_TIMERS-1:0] r_active;
    logic                  r_strobe;
    logic                  r_fired;
    logic                  r_running;

    logic                  accept;
    logic [IDX_EXT_W-1:0]  idx_ext;
    logic                  idx_ok;
    logic [AW-1:0]         addr;
    logic [EW-1:0]         rd_entry;
    logic [EW-1:0]         wr_entry;
    logic                  cur_active;
    t_upd_res              res;

    assign accept  = i_start && !r_busy;
    assign idx_ext = IDX_EXT_W'(i_timer_index);
    assign idx_ok  = idx_ext < IDX_EXT_W'(NUM_TIMERS);
    assign addr    = idx_ext[AW-1:0];

    assign cur_active = r_idx_ok ? r_active[r_addr] : 1'b0;

    // write of one request lands before the next request's read, no forwarding
    ptb_mem #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (r_busy && r_idx_ok && res.we),
        .i_waddr (r_addr),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (rd_entry)
    );

    ptb_upd #(
        .TICK_BITS (TICK_BITS)
    ) u_upd (
        .i_action        (r_action),
        .i_idx_ok        (r_idx_ok),
        .i_active        (cur_active),
        .i_entry         (rd_entry),
        .i_tick          (r_tick),
        .i_start_count   (r_start),
        .i_reload_period (r_period),
        .o_entry         (wr_entry),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_tick   <= '0;
            r_active <= '0;
        end else begin
            r_strobe <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                if (r_action == ACT_TICK) begin
                    r_tick <= r_tick + TICK_BITS'(1);
                end else if (r_idx_ok) begin
                    r_active[r_addr] <= res.active;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_idx_ok <= idx_ok;
            r_addr   <= addr;
            r_start  <= i_start_count;
            r_period <= i_reload_period;
        end
        if (r_busy) begin
            r_fired   <= res.fired;
            r_running <= res.running;
        end
    end

    assign o_busy          = r_busy;
    assign o_strobe        = r_strobe;
    assign o_fired         = r_strobe && r_fired;
    assign o_still_running = r_strobe && r_running;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("request accepted but no modify cycle followed");
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (o_strobe && !o_busy))
        else $error("modify cycle not followed by a single result");
    a_fire_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && res.fired) |-> (r_action == ACT_POLL && r_idx_ok))
        else $error("fired on a request other than a valid poll");
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_action != ACT_TICK) |=> $stable(r_tick))
        else $error("tick counter moved without a tick request");
`endif

endmodule
